FILE: rtl/tcc_pkg.sv
// Shared types, constants and the natural log table of the thermistor temperature converter.
package tcc_pkg;

  localparam int AdcBits = 10;
  localparam int LnEntries = 256;
  localparam int LnIdxBits = 8;
  localparam int CcBits = 17;
  localparam int RatioBits = 30;
  localparam int ResBits = 20;
  localparam int BetaBits = 14;
  localparam int LnBits = 38;
  localparam int TempBits = 17;

  localparam int T0Centi = 29815;
  localparam int ZeroCCenti = 27315;
  localparam int TempMax = 65535;

  localparam logic [2:0] CfgCalHalf = 3'd0;
  localparam logic [2:0] CfgCal3q   = 3'd1;
  localparam logic [2:0] CfgSeries  = 3'd2;
  localparam logic [2:0] CfgNominal = 3'd3;
  localparam logic [2:0] CfgBeta    = 3'd4;

  typedef enum logic [1:0] {
    ErrOk       = 2'd0,
    ErrCalEqual = 2'd1,
    ErrRange    = 2'd2
  } tcc_err_e;

  typedef struct packed {
    logic             valid;
    tcc_err_e         err;
    logic [CcBits-1:0] cc;
  } tcc_side_t;

  typedef logic [LnEntries:0][31:0] ln_rom_t;

  // Shift and subtract quotient, used only while the table is built.
  function automatic longint unsigned div_u64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // Entry i holds ln(1 + i/N) in Q0.32, from 2 * atanh(i / (2N + i)).
  function automatic ln_rom_t build_ln_rom();
    ln_rom_t rom;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned p;
    longint unsigned s;
    longint unsigned j;
    rom = '0;
    for (int i = 0; i <= LnEntries; i++) begin
      u = div_u64(64'(i) << 32, 64'(2 * LnEntries + i));
      u2 = (u * u) >> 32;
      p = u;
      s = u;
      j = 3;
      while (j < 80 && p != 0) begin
        p = (p * u2) >> 32;
        s = s + div_u64(p, j);
        j = j + 2;
      end
      rom[i] = 32'(2 * s);
    end
    return rom;
  endfunction

  localparam ln_rom_t LnRom = build_ln_rom();
  localparam logic [31:0] Ln2 = LnRom[LnEntries];

endpackage

FILE: rtl/thermistor_counts_to_temperature.sv
// Top level of the thermistor counts to temperature converter.
// One sample is taken in every clock cycle (busy stays low) and its result
// appears on done_o after passing through the two pipelined restoring
// dividers, 29 stages for the divider ratio and 17 stages for the
// temperature, and the six-stage log unit. Results are shown for one cycle
// only and cannot be held off, so the receiver must take every done_o
// transaction. Configuration transactions are always taken and must only be
// issued while no sample is in flight.
module thermistor_counts_to_temperature (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [tcc_pkg::AdcBits-1:0]         sample_counts_i,
  output logic                                done_o,
  output logic signed [tcc_pkg::TempBits-1:0] temperature_centi_o,
  output logic [tcc_pkg::CcBits-1:0]          counts_centi_o,
  output logic [1:0]                          error_code_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [2:0]                          cfg_index_i,
  input  logic [tcc_pkg::ResBits-1:0]         cfg_data_i
);
  import tcc_pkg::*;

  localparam int LnLatency = 6;
  localparam int Latency = 62;

  logic [AdcBits-1:0]   cal_half_q, cal_3q_q;
  logic [ResBits-1:0]   series_q, nominal_q;
  logic [BetaBits-1:0]  beta_q;

  tcc_side_t            side_r, side_t;
  tcc_side_t            side_ln_q [LnLatency];
  logic [RatioBits-1:0] ratio, ratio_c;
  logic [LnBits-1:0]    ln_a, ln_b;
  logic signed [TempBits-1:0] temp;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_half_q <= AdcBits'(512);
      cal_3q_q   <= AdcBits'(767);
      series_q   <= ResBits'(13000);
      nominal_q  <= ResBits'(10000);
      beta_q     <= BetaBits'(3950);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgCalHalf: cal_half_q <= cfg_data_i[AdcBits-1:0];
        CfgCal3q:   cal_3q_q   <= cfg_data_i[AdcBits-1:0];
        CfgSeries:  series_q   <= cfg_data_i;
        CfgNominal: nominal_q  <= cfg_data_i;
        CfgBeta:    beta_q     <= cfg_data_i[BetaBits-1:0];
        default: begin
        end
      endcase
    end
  end

  tcc_ratio u_ratio (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start && !busy),
    .sample_i   (sample_counts_i),
    .cal_half_i (cal_half_q),
    .cal_3q_i   (cal_3q_q),
    .side_o     (side_r),
    .ratio_o    (ratio),
    .ratio_c_o  (ratio_c)
  );

  tcc_ln u_ln_a (
    .clk_i (clk_i),
    .res_i (series_q),
    .fac_i (ratio),
    .ln_o  (ln_a)
  );

  tcc_ln u_ln_b (
    .clk_i (clk_i),
    .res_i (nominal_q),
    .fac_i (ratio_c),
    .ln_o  (ln_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LnLatency; i++) begin
        side_ln_q[i] <= '0;
      end
    end else begin
      side_ln_q[0] <= side_r;
      for (int i = 1; i < LnLatency; i++) begin
        side_ln_q[i] <= side_ln_q[i-1];
      end
    end
  end

  tcc_temp u_temp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .side_i    (side_ln_q[LnLatency-1]),
    .ln_a_i    (ln_a),
    .ln_b_i    (ln_b),
    .beta_i    (beta_q),
    .rs_zero_i (series_q == '0),
    .rn_zero_i (nominal_q == '0),
    .side_o    (side_t),
    .temp_o    (temp)
  );

  assign done_o              = side_t.valid;
  assign temperature_centi_o = temp;
  assign counts_centi_o      = side_t.cc;
  assign error_code_o        = side_t.err;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("Result strobe missing after an accepted sample.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("Result strobe without a matching sample.");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_code_o != ErrOk) |-> (temperature_centi_o == '0))
    else $error("Temperature not zero on an error result.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (temperature_centi_o >= -TempBits'(ZeroCCenti)))
    else $error("Temperature below absolute zero.");

endmodule

FILE: rtl/tcc_ratio.sv
// Divider ratio stage: maps a sample to a Q0.30 ratio and its complement through a pipelined restoring divider.
module tcc_ratio (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [tcc_pkg::AdcBits-1:0]       sample_i,
  input  logic [tcc_pkg::AdcBits-1:0]       cal_half_i,
  input  logic [tcc_pkg::AdcBits-1:0]       cal_3q_i,
  output tcc_pkg::tcc_side_t                side_o,
  output logic [tcc_pkg::RatioBits-1:0]     ratio_o,
  output logic [tcc_pkg::RatioBits-1:0]     ratio_c_o
);
  import tcc_pkg::*;

  localparam int QBits = 29;
  localparam logic [RatioBits-1:0] Half = RatioBits'(1) << QBits;

  typedef struct packed {
    logic [AdcBits:0]   rem;
    logic [QBits-1:0]   low;
    logic [QBits-1:0]   quo;
    logic [AdcBits:0]   dv;
    logic               neg;
    logic               ovf;
    logic               eq;
    logic [CcBits-1:0]  cc;
  } div_t;

  logic signed [AdcBits:0] x_d, dd_d;
  logic [AdcBits-1:0]      ax_d, ad_d;
  logic [CcBits-1:0]       cc_d;

  logic                    v1_q;
  logic [AdcBits-1:0]      ax_q, ad_q;
  logic                    neg_q, eq_q;
  logic [CcBits-1:0]       cc_q;

  div_t                    st_d [QBits+1];
  div_t                    st_q [QBits+1];
  logic [QBits:0]          vld_q;
  logic [AdcBits+1:0]      t;
  logic                    ge;

  tcc_side_t               side_d, side_q;
  logic [RatioBits-1:0]    ratio_d, ratio_q, ratio_c_d, ratio_c_q;

  assign x_d  = $signed({1'b0, sample_i}) - $signed({1'b0, cal_half_i});
  assign dd_d = $signed({1'b0, cal_3q_i}) - $signed({1'b0, cal_half_i});
  assign ax_d = x_d[AdcBits] ? AdcBits'(-x_d) : x_d[AdcBits-1:0];
  assign ad_d = dd_d[AdcBits] ? AdcBits'(-dd_d) : dd_d[AdcBits-1:0];
  assign cc_d = {{(CcBits-AdcBits){1'b0}}, sample_i} * CcBits'(100);

  always_comb begin
    st_d[0].rem = {1'b0, ax_q};
    st_d[0].low = {{(QBits-AdcBits){1'b0}}, ad_q};
    st_d[0].quo = '0;
    st_d[0].dv  = {ad_q, 1'b0};
    st_d[0].neg = neg_q;
    st_d[0].ovf = {1'b0, ax_q} >= {ad_q, 1'b0};
    st_d[0].eq  = eq_q;
    st_d[0].cc  = cc_q;
    t  = '0;
    ge = 1'b0;
    for (int k = 0; k < QBits; k++) begin
      t  = {st_q[k].rem, st_q[k].low[QBits-1]};
      ge = t >= {1'b0, st_q[k].dv};
      st_d[k+1]     = st_q[k];
      st_d[k+1].low = st_q[k].low << 1;
      st_d[k+1].quo = {st_q[k].quo[QBits-2:0], ge};
      st_d[k+1].rem = ge ? (AdcBits+1)'(t - {1'b0, st_q[k].dv}) : t[AdcBits:0];
    end
  end

  always_comb begin
    side_d.valid = vld_q[QBits];
    side_d.cc    = st_q[QBits].cc;
    if (st_q[QBits].eq) begin
      side_d.err = ErrCalEqual;
    end else if (st_q[QBits].ovf) begin
      side_d.err = ErrRange;
    end else begin
      side_d.err = ErrOk;
    end
    if (st_q[QBits].neg) begin
      ratio_d   = Half - RatioBits'(st_q[QBits].quo);
      ratio_c_d = Half + RatioBits'(st_q[QBits].quo);
    end else begin
      ratio_d   = Half + RatioBits'(st_q[QBits].quo);
      ratio_c_d = Half - RatioBits'(st_q[QBits].quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      vld_q  <= '0;
      side_q <= '0;
    end else begin
      v1_q   <= valid_i;
      vld_q  <= {vld_q[QBits-1:0], v1_q};
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q      <= ax_d;
    ad_q      <= ad_d;
    neg_q     <= x_d[AdcBits] ^ dd_d[AdcBits];
    eq_q      <= (dd_d == '0);
    cc_q      <= cc_d;
    st_q      <= st_d;
    ratio_q   <= ratio_d;
    ratio_c_q <= ratio_c_d;
  end

  assign side_o    = side_q;
  assign ratio_o   = ratio_q;
  assign ratio_c_o = ratio_c_q;

endmodule

FILE: rtl/tcc_ln.sv
// Pipelined natural log of a resistance product, table lookup with linear interpolation.
module tcc_ln (
  input  logic                          clk_i,
  input  logic [tcc_pkg::ResBits-1:0]   res_i,
  input  logic [tcc_pkg::RatioBits-1:0] fac_i,
  output logic [tcc_pkg::LnBits-1:0]    ln_o
);
  import tcc_pkg::*;

  localparam int VBits = ResBits + RatioBits;
  localparam int KBits = 6;

  logic [VBits-1:0]   v_q, v2_q, norm;
  logic [KBits-1:0]   k_d, k2_q, k3_q, k4_q;
  logic [31:0]        f_q;
  logic [LnIdxBits-1:0] idx;
  logic [31:0]        a_d, b_d, a4_q, a5_q, diff_q;
  logic [23:0]        fr_q;
  logic [55:0]        prod_q;
  logic [LnBits-1:0]  kl_q, ln_q;

  always_comb begin
    k_d = '0;
    for (int b = 0; b < VBits; b++) begin
      if (v_q[b]) begin
        k_d = KBits'(b);
      end
    end
  end

  assign norm = v2_q << (KBits'(VBits - 1) - k2_q);
  assign idx  = f_q[31:24];
  assign a_d  = LnRom[{1'b0, idx}];
  assign b_d  = LnRom[{1'b0, idx} + (LnIdxBits+1)'(1)];

  always_ff @(posedge clk_i) begin
    v_q    <= VBits'({{(VBits-ResBits){1'b0}}, res_i} * {{(VBits-RatioBits){1'b0}}, fac_i});
    v2_q   <= v_q;
    k2_q   <= k_d;
    f_q    <= norm[VBits-2:VBits-33];
    k3_q   <= k2_q;
    a4_q   <= a_d;
    diff_q <= b_d - a_d;
    fr_q   <= f_q[23:0];
    k4_q   <= k3_q;
    prod_q <= {24'b0, diff_q} * {32'b0, fr_q};
    kl_q   <= LnBits'(k4_q) * LnBits'(Ln2);
    a5_q   <= a4_q;
    ln_q   <= LnBits'(a5_q) + LnBits'(prod_q[55:24]) + kl_q;
  end

  assign ln_o = ln_q;

endmodule

FILE: rtl/tcc_temp.sv
// Temperature stage: beta equation denominator and a pipelined divider with saturation.
module tcc_temp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tcc_pkg::tcc_side_t                 side_i,
  input  logic [tcc_pkg::LnBits-1:0]         ln_a_i,
  input  logic [tcc_pkg::LnBits-1:0]         ln_b_i,
  input  logic [tcc_pkg::BetaBits-1:0]       beta_i,
  input  logic                               rs_zero_i,
  input  logic                               rn_zero_i,
  output tcc_pkg::tcc_side_t                 side_o,
  output logic signed [tcc_pkg::TempBits-1:0] temp_o
);
  import tcc_pkg::*;

  localparam int QBits = 17;
  localparam int Depth = 23;
  localparam int LrBits = LnBits + 1;
  localparam logic [45:0] T0Wide = 46'(T0Centi);
  localparam logic [35:0] NumScale = 36'(100 * T0Centi);
  localparam logic [QBits-1:0] QMax = QBits'(TempMax + ZeroCCenti);
  localparam logic signed [TempBits-1:0] TempHot = TempBits'(TempMax);
  localparam logic signed [TempBits-1:0] TempCold = -TempBits'(ZeroCCenti);

  typedef struct packed {
    logic [47:0]      rem;
    logic [QBits-1:0] low;
    logic [QBits-1:0] quo;
    logic [47:0]      dp;
    logic             ovf;
    logic             denpos;
  } div_t;

  tcc_side_t               sd_q [Depth];
  tcc_side_t               side_q;

  logic signed [LrBits-1:0] lr_q;
  logic [LrBits-1:0]       mag_q;
  logic                    sgn2_q, sgn3_q;
  logic [45:0]             m_q;
  logic [20:0]             b100_q;
  logic [35:0]             num_q, num4_q;
  logic signed [47:0]      den_q;
  logic [61:0]             np_q;
  logic [47:0]             dp_q;
  logic                    denpos_q;

  div_t                    st_d [QBits+1];
  div_t                    st_q [QBits+1];
  logic [48:0]             t;
  logic                    ge;

  logic                    hot;
  logic signed [TempBits-1:0] temp_d, temp_q;

  always_comb begin
    st_d[0].rem    = {3'b0, np_q[61:17]};
    st_d[0].low    = np_q[16:0];
    st_d[0].quo    = '0;
    st_d[0].dp     = dp_q;
    st_d[0].ovf    = {3'b0, np_q} >= {dp_q, 17'b0};
    st_d[0].denpos = denpos_q;
    t  = '0;
    ge = 1'b0;
    for (int k = 0; k < QBits; k++) begin
      t  = {st_q[k].rem, st_q[k].low[QBits-1]};
      ge = t >= {1'b0, st_q[k].dp};
      st_d[k+1]     = st_q[k];
      st_d[k+1].low = st_q[k].low << 1;
      st_d[k+1].quo = {st_q[k].quo[QBits-2:0], ge};
      st_d[k+1].rem = ge ? 48'(t - {1'b0, st_q[k].dp}) : t[47:0];
    end
  end

  always_comb begin
    hot = !st_q[QBits].denpos || st_q[QBits].ovf || (st_q[QBits].quo > QMax);
    if (sd_q[Depth-1].err != ErrOk) begin
      temp_d = '0;
    end else if (rs_zero_i) begin
      temp_d = TempHot;
    end else if (rn_zero_i) begin
      temp_d = TempCold;
    end else if (hot) begin
      temp_d = TempHot;
    end else begin
      temp_d = $signed(st_q[QBits].quo - QBits'(ZeroCCenti));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        sd_q[i] <= '0;
      end
      side_q <= '0;
    end else begin
      sd_q[0] <= side_i;
      for (int i = 1; i < Depth; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
      side_q <= sd_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    lr_q     <= $signed({1'b0, ln_a_i}) - $signed({1'b0, ln_b_i});
    mag_q    <= lr_q[LrBits-1] ? (LrBits'($unsigned(~lr_q)) + LrBits'(129))
                               : (LrBits'($unsigned(lr_q)) + LrBits'(128));
    sgn2_q   <= lr_q[LrBits-1];
    m_q      <= {15'b0, mag_q[LrBits-1:8]} * T0Wide;
    b100_q   <= {7'b0, beta_i} * 21'd100;
    num_q    <= {22'b0, beta_i} * NumScale;
    sgn3_q   <= sgn2_q;
    den_q    <= sgn3_q ? ($signed({3'b0, b100_q, 24'b0}) - $signed({2'b0, m_q}))
                       : ($signed({3'b0, b100_q, 24'b0}) + $signed({2'b0, m_q}));
    num4_q   <= num_q;
    np_q     <= {1'b0, num4_q, 25'b0} + {15'b0, den_q[46:0]};
    dp_q     <= {den_q[46:0], 1'b0};
    denpos_q <= !den_q[47] && (den_q != '0);
    st_q     <= st_d;
    temp_q   <= temp_d;
  end

  assign side_o = side_q;
  assign temp_o = temp_q;

endmodule

FILE: tb/sv/thermistor_counts_to_temperature_tb.sv
// Self-checking testbench for the thermistor counts to temperature converter.
`timescale 1ns / 100ps

module thermistor_counts_to_temperature_tb;
  import tcc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 80;
  localparam longint unsigned Mask32 = 64'hFFFF_FFFF;

  typedef struct {
    logic [TempBits-1:0] temp;
    logic [CcBits-1:0] cc;
    tcc_err_e err;
  } temp_reading_t;

  logic clk;
  logic rst_ni;
  logic start;
  logic busy;
  logic [AdcBits-1:0] sample_counts;
  logic done;
  logic signed [TempBits-1:0] temperature_centi;
  logic [CcBits-1:0] counts_centi;
  logic [1:0] error_code;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [ResBits-1:0] cfg_data;

  longint unsigned log_tab [0:LnEntries];
  longint unsigned cal_half, cal_3q, res_series, res_nominal, beta;
  temp_reading_t pending_readings[$];
  int mismatches = 0;
  int samples_sent = 0;
  int readings_seen = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;

  thermistor_counts_to_temperature dut (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .sample_counts_i(sample_counts),
    .done_o(done),
    .temperature_centi_o(temperature_centi),
    .counts_centi_o(counts_centi),
    .error_code_o(error_code),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic fill_log_table();
    longint unsigned u, u2, p, acc, j;
    for (int i = 0; i <= LnEntries; i++) begin
      u = (longint'(i) << 32) / longint'(2 * LnEntries + i);
      u2 = (u * u) >> 32;
      p = u;
      acc = u;
      j = 3;
      while (j < 80 && p != 0) begin
        p = (p * u2) >> 32;
        acc = acc + p / j;
        j = j + 2;
      end
      log_tab[i] = 2 * acc;
    end
  endtask

  function automatic longint log_q32(longint unsigned v);
    int k;
    longint unsigned f, idx, frac, a, b;
    k = 0;
    while (k < 63 && (v >> (k + 1)) != 0) k++;
    if (k >= 32) f = (v >> (k - 32)) & Mask32;
    else f = (v << (32 - k)) & Mask32;
    idx = f >> 24;
    frac = (f << 8) & Mask32;
    a = log_tab[idx];
    b = log_tab[idx + 1];
    a = a + (((b - a) * frac) >> 32);
    return longint'(longint'(k) * log_tab[LnEntries] + a);
  endfunction

  function automatic longint nearest_div(longint n, longint d);
    longint unsigned an, ad, q;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic temp_reading_t convert_sample(logic [AdcBits-1:0] s);
    temp_reading_t r;
    longint span, ratio, l24, den, num, t;
    t = 0;
    r.err = ErrOk;
    span = longint'(cal_3q) - longint'(cal_half);
    if (span == 0) begin
      r.err = ErrCalEqual;
    end else begin
      ratio = (longint'(1) << 29) +
              nearest_div((longint'(s) - longint'(cal_half)) * (longint'(1) << 28), span);
      if (ratio <= 0 || ratio >= (longint'(1) << 30)) begin
        r.err = ErrRange;
      end else if (res_series == 0) begin
        t = TempMax;
      end else if (res_nominal == 0) begin
        t = -ZeroCCenti;
      end else begin
        l24 = nearest_div(log_q32(res_series * ratio) -
                          log_q32(res_nominal * ((longint'(1) << 30) - ratio)), 256);
        den = 100 * longint'(beta) * (longint'(1) << 24) + longint'(T0Centi) * l24;
        if (den <= 0) begin
          t = TempMax;
        end else begin
          num = 100 * longint'(beta) * longint'(T0Centi) * (longint'(1) << 24);
          t = (2 * num + den) / (2 * den) - ZeroCCenti;
          if (t > TempMax) t = TempMax;
          if (t < -ZeroCCenti) t = -ZeroCCenti;
        end
      end
    end
    r.temp = t[TempBits-1:0];
    r.cc = CcBits'(longint'(s) * 100);
    return r;
  endfunction

  always @(posedge clk) begin
    temp_reading_t e;
    if (rst_ni && done) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reading at cycle %0d", cycles);
      end else begin
        e = pending_readings.pop_front();
        if (temperature_centi !== e.temp || counts_centi !== e.cc || error_code !== e.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: temp %0d/%0d cc %0d/%0d err %0d/%0d (expected/actual)",
                     $signed(e.temp), temperature_centi, e.cc, counts_centi,
                     e.err, error_code);
        end
      end
    end
  end

  task automatic send_sample(logic [AdcBits-1:0] s);
    if (gaps_on && $urandom_range(99) < 37) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    sample_counts <= s;
    do @(posedge clk); while (busy);
    pending_readings.push_back(convert_sample(s));
    samples_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [ResBits-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CfgCalHalf: cal_half = val[AdcBits-1:0];
      CfgCal3q: cal_3q = val[AdcBits-1:0];
      CfgSeries: res_series = val;
      CfgNominal: res_nominal = val;
      CfgBeta: beta = val[BetaBits-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int ch, int c3q, int rs, int rn, int bk);
    write_reg(CfgCalHalf, ResBits'(ch));
    write_reg(CfgCal3q, ResBits'(c3q));
    write_reg(CfgSeries, ResBits'(rs));
    write_reg(CfgNominal, ResBits'(rn));
    write_reg(CfgBeta, ResBits'(bk));
  endtask

  task automatic test_default_extremes();
    int pts[8] = '{0, 1023, 512, 767, 511, 256, 1, 1022};
    foreach (pts[i]) send_sample(AdcBits'(pts[i]));
    send_sample(10'h2AA);
    send_sample(10'h155);
  endtask

  task automatic test_calibration_equal();
    set_config(300, 300, 13000, 10000, 3950);
    send_sample(0);
    send_sample(300);
    send_sample(1023);
  endtask

  task automatic test_zero_and_extreme_registers();
    set_config(512, 767, 0, 10000, 3950);
    send_sample(600);
    set_config(512, 767, 13000, 0, 3950);
    send_sample(600);
    set_config(512, 767, 13000, 10000, 0);
    send_sample(300);
    send_sample(900);
    set_config(1023, 0, 1048575, 1, 16383);
    send_sample(700);
    send_sample(1000);
    set_config(0, 1023, 1, 1048575, 1);
    send_sample(100);
    send_sample(1000);
  endtask

  task automatic test_random_phases();
    int ch, c3q;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) begin
        set_config(512, 767, 13000, 10000, 3950);
      end else begin
        ch = $urandom_range(1023);
        c3q = ($urandom_range(9) == 0) ? ch : $urandom_range(1023);
        set_config(ch, c3q, $urandom_range(20'hFFFFF), $urandom_range(20'hFFFFF),
                   $urandom_range(16383));
      end
      gaps_on = (ph != 6);
      for (int n = 0; n < 190; n++) begin
        if ($urandom_range(3) == 0) send_sample(AdcBits'($urandom_range(1023)));
        else send_sample(AdcBits'(longint'(cal_half) +
                         (longint'(cal_3q) - longint'(cal_half)) *
                         (longint'($urandom_range(1800)) - 900) / 450));
      end
      gaps_on = 1'b1;
    end
  endtask

  initial begin
    fill_log_table();
    cal_half = 512;
    cal_3q = 767;
    res_series = 13000;
    res_nominal = 10000;
    beta = 3950;
    rst_ni = 1'b0;
    start = 1'b0;
    sample_counts = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgCalHalf;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_default_extremes();
    test_calibration_equal();
    test_zero_and_extreme_registers();
    test_random_phases();
    drain();
    repeat (DrainCycles) @(posedge clk);
    $display("sent %0d samples over directed and random register settings, %0d readings",
             samples_sent, readings_seen);
    $display("checked including equal calibration, out-of-range ratio and zero registers");
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d readings missing", mismatches, pending_readings.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tcc_pkg.sv
rtl/tcc_ratio.sv
rtl/tcc_ln.sv
rtl/tcc_temp.sv
rtl/thermistor_counts_to_temperature.sv
tb/sv/thermistor_counts_to_temperature_tb.sv
